### rtl/pif_pkg.sv
// Shared constants for the integer formatter: radix codes, flag bit positions,
// field limits and the ASCII codes that the formatter emits.
// No dependencies; the interfaces and the top level use it by scoped names.
package pif_pkg;

   // Field widths of a request and a response.
   localparam int ValueWidth = 32;
   localparam int ModeWidth  = 2;
   localparam int FlagsWidth = 7;
   localparam int FieldWidth = 6;
   localparam int CharWidth  = 8;

   // Widest field that padding honors; larger requests saturate here.
   localparam logic [FieldWidth-1:0] MAX_WIDTH = 6'd62;

   // Radix selector codes; the unused code behaves as decimal.
   localparam logic [ModeWidth-1:0] MODE_DEC = 2'd0;
   localparam logic [ModeWidth-1:0] MODE_OCT = 2'd1;
   localparam logic [ModeWidth-1:0] MODE_HEX = 2'd2;

   // Flag bit positions.
   localparam int FLAG_SIGNED = 0;
   localparam int FLAG_PLUS   = 1;
   localparam int FLAG_SPACE  = 2;
   localparam int FLAG_PREFIX = 3;
   localparam int FLAG_ZPAD   = 4;
   localparam int FLAG_LEFT   = 5;
   localparam int FLAG_UPPER  = 6;

   // Digit register: eleven 4-bit digits cover the longest octal text.
   localparam int NumDigits = 11;
   localparam int DigBits   = 4 * NumDigits;
   localparam int BcdDigits = 10;

   // ASCII codes.
   localparam logic [CharWidth-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CharWidth-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CharWidth-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CharWidth-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CharWidth-1:0] CHAR_X     = 8'h78;
   localparam logic [CharWidth-1:0] CHAR_LA    = 8'h61;
   localparam logic [CharWidth-1:0] CHAR_UA    = 8'h41;

endpackage

### rtl/pif_req_if.sv
// Request channel of the integer formatter: valid/ready handshake and payload.
// Depends on pif_pkg for the field widths.
interface pif_req_if;
   logic                               valid;
   logic                               ready;
   logic [pif_pkg::ValueWidth-1:0]     value;
   logic [pif_pkg::ModeWidth-1:0]      mode;
   logic [pif_pkg::FlagsWidth-1:0]     flags;
   logic [pif_pkg::FieldWidth-1:0]     field_width;

   modport source (output valid, value, mode, flags, field_width, input ready);
   modport sink   (input valid, value, mode, flags, field_width, output ready);
endinterface

### rtl/pif_rsp_if.sv
// Response channel of the integer formatter: one ASCII character per transfer, last on the final one.
// Depends on pif_pkg for the character width.
interface pif_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [pif_pkg::CharWidth-1:0]      char_out;
   logic                               last;

   modport source (output valid, char_out, last, input ready);
   modport sink   (input valid, char_out, last, output ready);
endinterface

### rtl/printf_integer_formatter.sv
// Integer formatter: turns one 32-bit value into its ASCII text, one char per response.
// Sequence: decimal loads the request, converts it (one bit per cycle), then strips
// leading zeros and sizes the padding; octal and hex skip the conversion. Then one
// character per cycle while the response side accepts, up to 64.
// Requests are taken one at a time, only while the sequencer is idle.
// Reset (synchronous, active high) returns the sequencer to idle and drops rsp valid.
module printf_integer_formatter (
   input  logic      clock,
   input  logic      reset,
   pif_req_if.sink   req_chan,
   pif_rsp_if.source rsp_chan
);

   typedef enum logic [3:0] {
      S_IDLE, S_CONV, S_STRIP, S_PRE0, S_PREX, S_LPAD, S_SIGN, S_DIG, S_RPAD
   } state_type;

   typedef enum logic [1:0] {SG_NONE, SG_MINUS, SG_PLUS, SG_SPACE} sign_type;

   state_type                            state_ff, state_in;
   sign_type                             sign_ff, sign_in;
   logic [pif_pkg::ValueWidth-1:0]       val_ff, val_in;
   logic [pif_pkg::DigBits-1:0]          dig_ff, dig_in;
   logic [4:0]                           bit_cnt_ff, bit_cnt_in;
   logic [3:0]                           nd_ff, nd_in;
   logic [pif_pkg::FieldWidth-1:0]       pad_ff, pad_in;
   logic [pif_pkg::FieldWidth-1:0]       width_ff, width_in;
   logic [pif_pkg::ModeWidth-1:0]        mode_ff, mode_in;
   logic [pif_pkg::FlagsWidth-1:0]       flags_ff, flags_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [pif_pkg::CharWidth-1:0]        char_ff, char_in;
   logic                                 last_ff, last_in;

   logic                                 accept;
   logic                                 out_free;
   logic [pif_pkg::ValueWidth-1:0]       mag;
   logic [pif_pkg::DigBits-1:0]          oct_dig;
   logic [4*pif_pkg::BcdDigits-1:0]      bcd_adj;
   logic [pif_pkg::FieldWidth-1:0]       body;
   logic [pif_pkg::FieldWidth-1:0]       pad_calc;
   logic [3:0]                           top_dig;
   logic [pif_pkg::CharWidth-1:0]        dig_char;
   logic                                 left_j;
   logic                                 zero_p;
   logic                                 has_sign;

   assign accept         = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.char_out = char_ff;
   assign rsp_chan.last     = last_ff;

   assign left_j   = flags_ff[pif_pkg::FLAG_LEFT];
   assign zero_p   = flags_ff[pif_pkg::FLAG_ZPAD];
   assign has_sign = (sign_ff != SG_NONE);

   // Magnitude: negate in signed mode when the top bit is set.
   assign mag = (req_chan.flags[pif_pkg::FLAG_SIGNED] && req_chan.value[pif_pkg::ValueWidth-1])
                ? (~req_chan.value + 32'd1) : req_chan.value;

   // Octal digits are 3-bit groups, each widened to a 4-bit digit slot.
   always_comb begin
      logic [3*pif_pkg::NumDigits-1:0] v33;
      v33 = {1'b0, mag};
      for (int k = 0; k < pif_pkg::NumDigits; k++) begin
         oct_dig[4*k +: 4] = {1'b0, v33[3*k +: 3]};
      end
   end

   // Double-dabble correction: every BCD digit of 5 or more gets 3 added.
   always_comb begin
      for (int k = 0; k < pif_pkg::BcdDigits; k++) begin
         bcd_adj[4*k +: 4] = (dig_ff[4*k +: 4] >= 4'd5) ? (dig_ff[4*k +: 4] + 4'd3)
                                                         : dig_ff[4*k +: 4];
      end
   end

   // Padding is the width left over after the sign and the digits.
   assign body     = {2'b00, nd_ff} + {5'd0, has_sign};
   assign pad_calc = (width_ff > body) ? (width_ff - body) : '0;

   // Character for the most significant remaining digit.
   assign top_dig = dig_ff[pif_pkg::DigBits-1 -: 4];
   always_comb begin
      if (top_dig < 4'd10) begin
         dig_char = pif_pkg::CHAR_ZERO + {4'd0, top_dig};
      end else if (flags_ff[pif_pkg::FLAG_UPPER]) begin
         dig_char = pif_pkg::CHAR_UA + {4'd0, top_dig} - 8'd10;
      end else begin
         dig_char = pif_pkg::CHAR_LA + {4'd0, top_dig} - 8'd10;
      end
   end

   // First state of the body (sign, padding, digits), given the padding count.
   function automatic state_type body_start(input logic lj, input logic zp,
                                            input logic sg, input logic [5:0] pd);
      state_type st;
      if (lj) begin
         st = sg ? S_SIGN : S_DIG;
      end else if (zp) begin
         st = sg ? S_SIGN : ((pd != '0) ? S_LPAD : S_DIG);
      end else begin
         st = (pd != '0) ? S_LPAD : (sg ? S_SIGN : S_DIG);
      end
      return st;
   endfunction

   // Sequencer: load, convert (decimal only), strip leading zeros, then emit characters.
   always_comb begin
      state_in     = state_ff;
      sign_in      = sign_ff;
      val_in       = val_ff;
      dig_in       = dig_ff;
      bit_cnt_in   = bit_cnt_ff;
      nd_in        = nd_ff;
      pad_in       = pad_ff;
      width_in     = width_ff;
      mode_in      = mode_ff;
      flags_in     = flags_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      char_in      = char_ff;
      last_in      = last_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               flags_in   = req_chan.flags;
               mode_in    = req_chan.mode;
               width_in   = (req_chan.field_width > pif_pkg::MAX_WIDTH)
                            ? pif_pkg::MAX_WIDTH : req_chan.field_width;
               val_in     = mag;
               nd_in      = 4'(pif_pkg::NumDigits);
               bit_cnt_in = 5'd31;
               if (req_chan.flags[pif_pkg::FLAG_SIGNED] &&
                   req_chan.value[pif_pkg::ValueWidth-1]) begin
                  sign_in = SG_MINUS;
               end else if (req_chan.flags[pif_pkg::FLAG_PLUS]) begin
                  sign_in = SG_PLUS;
               end else if (req_chan.flags[pif_pkg::FLAG_SPACE]) begin
                  sign_in = SG_SPACE;
               end else begin
                  sign_in = SG_NONE;
               end
               if (req_chan.mode == pif_pkg::MODE_OCT) begin
                  dig_in   = oct_dig;
                  state_in = S_STRIP;
               end else if (req_chan.mode == pif_pkg::MODE_HEX) begin
                  dig_in   = {12'd0, mag};
                  state_in = S_STRIP;
               end else begin
                  dig_in   = '0;
                  state_in = S_CONV;
               end
            end
         end
         S_CONV: begin
            // One bit of the binary value shifts into the BCD digits each cycle.
            dig_in     = {4'd0, bcd_adj[4*pif_pkg::BcdDigits-2:0], val_ff[pif_pkg::ValueWidth-1]};
            val_in     = {val_ff[pif_pkg::ValueWidth-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff - 5'd1;
            if (bit_cnt_ff == '0) begin
               state_in = S_STRIP;
            end
         end
         S_STRIP: begin
            if (top_dig == 4'd0 && nd_ff > 4'd1) begin
               dig_in = {dig_ff[pif_pkg::DigBits-5:0], 4'd0};
               nd_in  = nd_ff - 4'd1;
            end else begin
               pad_in = pad_calc;
               if (flags_ff[pif_pkg::FLAG_PREFIX] &&
                   (mode_ff == pif_pkg::MODE_OCT || mode_ff == pif_pkg::MODE_HEX)) begin
                  state_in = S_PRE0;
               end else begin
                  state_in = body_start(left_j, zero_p, has_sign, pad_calc);
               end
            end
         end
         S_PRE0: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               char_in      = pif_pkg::CHAR_ZERO;
               last_in      = 1'b0;
               state_in     = (mode_ff == pif_pkg::MODE_HEX) ? S_PREX
                              : body_start(left_j, zero_p, has_sign, pad_ff);
            end
         end
         S_PREX: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               char_in      = pif_pkg::CHAR_X;
               last_in      = 1'b0;
               state_in     = body_start(left_j, zero_p, has_sign, pad_ff);
            end
         end
         S_SIGN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               last_in      = 1'b0;
               case (sign_ff)
                  SG_MINUS: char_in = pif_pkg::CHAR_MINUS;
                  SG_PLUS:  char_in = pif_pkg::CHAR_PLUS;
                  default:  char_in = pif_pkg::CHAR_SPACE;
               endcase
               state_in = (!left_j && zero_p && pad_ff != '0) ? S_LPAD : S_DIG;
            end
         end
         S_LPAD: begin
            // Leading padding: zeros after the sign, or spaces before it.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               char_in      = zero_p ? pif_pkg::CHAR_ZERO : pif_pkg::CHAR_SPACE;
               last_in      = 1'b0;
               pad_in       = pad_ff - 6'd1;
               if (pad_ff == 6'd1) begin
                  state_in = (!zero_p && has_sign) ? S_SIGN : S_DIG;
               end
            end
         end
         S_DIG: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               char_in      = dig_char;
               dig_in       = {dig_ff[pif_pkg::DigBits-5:0], 4'd0};
               nd_in        = nd_ff - 4'd1;
               last_in      = (nd_ff == 4'd1) && !(left_j && pad_ff != '0);
               if (nd_ff == 4'd1) begin
                  state_in = (left_j && pad_ff != '0) ? S_RPAD : S_IDLE;
               end
            end
         end
         S_RPAD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               char_in      = pif_pkg::CHAR_SPACE;
               last_in      = (pad_ff == 6'd1);
               pad_in       = pad_ff - 6'd1;
               if (pad_ff == 6'd1) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sign_ff    <= sign_in;
      val_ff     <= val_in;
      dig_ff     <= dig_in;
      bit_cnt_ff <= bit_cnt_in;
      nd_ff      <= nd_in;
      pad_ff     <= pad_in;
      width_ff   <= width_in;
      mode_ff    <= mode_in;
      flags_ff   <= flags_in;
      char_ff    <= char_in;
      last_ff    <= last_in;
   end

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for printf_integer_formatter: directed and random requests,
// each predicted to its ASCII text and compared character by character.
// Depends on pif_pkg, pif_req_if, pif_rsp_if and the formatter top level.
module tb;

   // Flag masks built from the package bit positions.
   localparam logic [pif_pkg::FlagsWidth-1:0] F_SIGNED = 7'b1 << pif_pkg::FLAG_SIGNED;
   localparam logic [pif_pkg::FlagsWidth-1:0] F_PLUS   = 7'b1 << pif_pkg::FLAG_PLUS;
   localparam logic [pif_pkg::FlagsWidth-1:0] F_SPACE  = 7'b1 << pif_pkg::FLAG_SPACE;
   localparam logic [pif_pkg::FlagsWidth-1:0] F_PREFIX = 7'b1 << pif_pkg::FLAG_PREFIX;
   localparam logic [pif_pkg::FlagsWidth-1:0] F_ZPAD   = 7'b1 << pif_pkg::FLAG_ZPAD;
   localparam logic [pif_pkg::FlagsWidth-1:0] F_LEFT   = 7'b1 << pif_pkg::FLAG_LEFT;
   localparam logic [pif_pkg::FlagsWidth-1:0] F_UPPER  = 7'b1 << pif_pkg::FLAG_UPPER;
   localparam logic [pif_pkg::FlagsWidth-1:0] F_ALL    = 7'h7F;

   // The radix code that the package leaves unused; it formats as decimal.
   localparam logic [pif_pkg::ModeWidth-1:0] MODE_SPARE = 2'd3;

   localparam int CycleLimit  = 1000000;
   localparam int SettleTicks = 60;

   typedef struct packed {
      logic [pif_pkg::CharWidth-1:0] code;
      logic                          last;
   } text_char_type;

   logic clock = 1'b0;
   logic reset;

   pif_req_if req_chan();
   pif_rsp_if rsp_chan();

   printf_integer_formatter dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   text_char_type expected_text[$];
   int            mismatches = 0;
   int            cycle_count = 0;
   bit            idle_on = 1'b1;
   int            stall_left = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: a run that never drains ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles, %0d characters still due",
                  cycle_count, expected_text.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   // Predict the text of one request and queue its characters.
   function automatic void queue_text(input logic [pif_pkg::ValueWidth-1:0] value,
                                      input logic [pif_pkg::ModeWidth-1:0]  mode,
                                      input logic [pif_pkg::FlagsWidth-1:0] flags,
                                      input logic [pif_pkg::FieldWidth-1:0] width);
      logic [pif_pkg::ValueWidth-1:0] mag;
      logic [pif_pkg::ValueWidth-1:0] radix;
      logic [pif_pkg::ValueWidth-1:0] rem;
      logic [pif_pkg::CharWidth-1:0]  digs [0:15];
      logic [pif_pkg::CharWidth-1:0]  sign_char;
      logic [pif_pkg::CharWidth-1:0]  line[$];
      text_char_type                  item;
      int                             nd;
      int                             w;
      int                             body;
      int                             pad;
      bit                             has_sign;
      mag = value;
      nd = 0;
      has_sign = 1'b0;
      sign_char = pif_pkg::CHAR_SPACE;
      radix = (mode == pif_pkg::MODE_OCT) ? 32'd8 :
              (mode == pif_pkg::MODE_HEX) ? 32'd16 : 32'd10;
      w = (width > pif_pkg::MAX_WIDTH) ? int'(pif_pkg::MAX_WIDTH) : int'(width);

      // Sign selection: a negative signed value wins over plus and space.
      if (flags[pif_pkg::FLAG_SIGNED] && value[pif_pkg::ValueWidth-1]) begin
         mag = -value;
         has_sign = 1'b1;
         sign_char = pif_pkg::CHAR_MINUS;
      end else if (flags[pif_pkg::FLAG_PLUS]) begin
         has_sign = 1'b1;
         sign_char = pif_pkg::CHAR_PLUS;
      end else if (flags[pif_pkg::FLAG_SPACE]) begin
         has_sign = 1'b1;
      end

      // Digits, least significant first; zero still yields one digit.
      do begin
         rem = mag % radix;
         mag = mag / radix;
         if (rem < 10)
            digs[nd] = pif_pkg::CHAR_ZERO + rem[pif_pkg::CharWidth-1:0];
         else if (flags[pif_pkg::FLAG_UPPER])
            digs[nd] = pif_pkg::CHAR_UA + rem[pif_pkg::CharWidth-1:0] - 8'd10;
         else
            digs[nd] = pif_pkg::CHAR_LA + rem[pif_pkg::CharWidth-1:0] - 8'd10;
         nd++;
      end while (mag != 0 && nd < 16);

      body = nd + (has_sign ? 1 : 0);
      pad = (w > body) ? w - body : 0;

      // The radix prefix sits outside the field width.
      if (flags[pif_pkg::FLAG_PREFIX]) begin
         if (mode == pif_pkg::MODE_OCT) begin
            line.push_back(pif_pkg::CHAR_ZERO);
         end else if (mode == pif_pkg::MODE_HEX) begin
            line.push_back(pif_pkg::CHAR_ZERO);
            line.push_back(pif_pkg::CHAR_X);
         end
      end

      if (flags[pif_pkg::FLAG_LEFT]) begin
         if (has_sign) line.push_back(sign_char);
         for (int i = nd; i > 0; i--) line.push_back(digs[i-1]);
         repeat (pad) line.push_back(pif_pkg::CHAR_SPACE);
      end else if (flags[pif_pkg::FLAG_ZPAD]) begin
         if (has_sign) line.push_back(sign_char);
         repeat (pad) line.push_back(pif_pkg::CHAR_ZERO);
         for (int i = nd; i > 0; i--) line.push_back(digs[i-1]);
      end else begin
         repeat (pad) line.push_back(pif_pkg::CHAR_SPACE);
         if (has_sign) line.push_back(sign_char);
         for (int i = nd; i > 0; i--) line.push_back(digs[i-1]);
      end

      foreach (line[i]) begin
         item.code = line[i];
         item.last = (i == line.size() - 1);
         expected_text.push_back(item);
      end
   endfunction

   // Values biased toward the interesting corners of 32 bits.
   function automatic logic [pif_pkg::ValueWidth-1:0] pick_value();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 99);
         1: return 32'h8000_0000 + $urandom_range(0, 15) - 8;
         2: return 32'hFFFF_FFFF - $urandom_range(0, 15);
         3: return 32'h1 << $urandom_range(0, 31);
         default: return $urandom;
      endcase
   endfunction

   // Send one request: optional idle burst, then hold valid until accepted.
   task automatic send_request(input logic [pif_pkg::ValueWidth-1:0] value,
                               input logic [pif_pkg::ModeWidth-1:0]  mode,
                               input logic [pif_pkg::FlagsWidth-1:0] flags,
                               input logic [pif_pkg::FieldWidth-1:0] width);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 3);
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.value = value;
      req_chan.mode = mode;
      req_chan.flags = flags;
      req_chan.field_width = width;
      req_chan.valid = 1'b1;
      do @(posedge clock); while (!req_chan.ready);
      queue_text(value, mode, flags, width);
      @(negedge clock);
   endtask

   // Stop sending and wait until every predicted character has come back.
   task automatic wait_for_text();
      req_chan.valid = 1'b0;
      while (expected_text.size() != 0) @(posedge clock);
      repeat (SettleTicks) @(posedge clock);
      @(negedge clock);
   endtask

   // Response stalls in short random bursts while idling is on.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_chan.ready = 1'b0;
         stall_left--;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
         rsp_chan.ready = 1'b0;
         stall_left = $urandom_range(0, 2);
      end else begin
         rsp_chan.ready = 1'b1;
      end
   end

   task automatic note_mismatch(input string what,
                                input logic [pif_pkg::CharWidth-1:0] want,
                                input logic [pif_pkg::CharWidth-1:0] got);
      if (mismatches < 10)
         $display("%s mismatch at cycle %0d: expected %02h, got %02h",
                  what, cycle_count, want, got);
      mismatches++;
   endtask

   // Compare each accepted character with the oldest prediction.
   always @(posedge clock) begin
      text_char_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_text.size() == 0) begin
            note_mismatch("unexpected character", 8'h00, rsp_chan.char_out);
         end else begin
            want = expected_text.pop_front();
            if (rsp_chan.char_out !== want.code)
               note_mismatch("char_out", want.code, rsp_chan.char_out);
            if (rsp_chan.last !== want.last)
               note_mismatch("last", {7'b0, want.last}, {7'b0, rsp_chan.last});
         end
      end
   end

   // Extremes of every field, each radix including the spare code, and the
   // corner cases: saturated width, digits wider than the field, zero pad
   // next to a sign, left justify overriding zero pad, prefix on zero.
   task automatic test_directed();
      send_request(32'h0000_0000, pif_pkg::MODE_DEC, 7'h00, 6'd0);
      send_request(32'h0000_0000, pif_pkg::MODE_OCT, F_PREFIX, 6'd0);
      send_request(32'h0000_0000, pif_pkg::MODE_HEX, F_PREFIX, 6'd5);
      send_request(32'hFFFF_FFFF, pif_pkg::MODE_DEC, F_SIGNED, 6'd0);
      send_request(32'hFFFF_FFFF, pif_pkg::MODE_DEC, 7'h00, 6'd0);
      send_request(32'h8000_0000, pif_pkg::MODE_DEC, F_SIGNED | F_ZPAD, 6'd15);
      send_request(32'h7FFF_FFFF, pif_pkg::MODE_DEC, F_PLUS, 6'd12);
      send_request(32'hFFFF_FFFF, pif_pkg::MODE_OCT, F_PREFIX | F_SPACE, 6'd0);
      send_request(32'hDEAD_BEEF, pif_pkg::MODE_HEX, F_UPPER | F_PREFIX, 6'd10);
      send_request(32'hDEAD_BEEF, pif_pkg::MODE_HEX, F_PREFIX, 6'd63);
      send_request(32'd12345, MODE_SPARE, F_PREFIX, 6'd8);
      send_request(32'h8000_0000, pif_pkg::MODE_DEC, F_SIGNED | F_LEFT | F_ZPAD, 6'd62);
      send_request(32'd1234567, pif_pkg::MODE_DEC, F_PLUS | F_SPACE, 6'd3);
      send_request(32'hFFFF_FFFF, pif_pkg::MODE_OCT,
                   F_PREFIX | F_LEFT | F_ZPAD | F_SIGNED, 6'd63);
      send_request(32'd42, pif_pkg::MODE_HEX, F_ALL, 6'd62);
      send_request(32'hABCD_EF01, pif_pkg::MODE_HEX, F_SPACE | F_ZPAD | F_UPPER, 6'd20);
      send_request(32'd5, pif_pkg::MODE_DEC, F_SPACE, 6'd1);
      send_request(32'hFFFF_FFFF, pif_pkg::MODE_HEX, F_SIGNED | F_PLUS | F_PREFIX, 6'd4);
      send_request(32'h0000_0007, pif_pkg::MODE_OCT, F_ZPAD | F_PLUS, 6'd63);
      send_request(32'h8000_0000, MODE_SPARE, F_SIGNED | F_SPACE | F_LEFT, 6'd40);
      wait_for_text();
   endtask

   // Fully random fields, every radix code and width.
   task automatic test_random_formats(input int count);
      for (int i = 0; i < count; i++)
         send_request(pick_value(), pif_pkg::ModeWidth'($urandom_range(0, 3)),
                      pif_pkg::FlagsWidth'($urandom), pif_pkg::FieldWidth'($urandom));
      wait_for_text();
   endtask

   // Signed values with sign and padding flags, mostly narrow fields.
   task automatic test_signed_padding(input int count);
      logic [pif_pkg::FieldWidth-1:0] width;
      logic [pif_pkg::FlagsWidth-1:0] flags;
      for (int i = 0; i < count; i++) begin
         width = ($urandom_range(0, 9) == 0) ? pif_pkg::FieldWidth'($urandom_range(56, 63))
                                             : pif_pkg::FieldWidth'($urandom_range(0, 24));
         flags = pif_pkg::FlagsWidth'($urandom) | F_SIGNED;
         send_request(pick_value(), pif_pkg::ModeWidth'($urandom_range(0, 3)), flags, width);
      end
      wait_for_text();
   endtask

   // Back-to-back requests with no idle gaps and the response side always ready.
   task automatic test_back_to_back(input int count);
      idle_on = 1'b0;
      for (int i = 0; i < count; i++)
         send_request(pick_value(), pif_pkg::ModeWidth'($urandom_range(0, 3)),
                      pif_pkg::FlagsWidth'($urandom),
                      pif_pkg::FieldWidth'($urandom_range(0, 20)));
      wait_for_text();
   endtask

   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.value = '0;
      req_chan.mode = pif_pkg::MODE_DEC;
      req_chan.flags = '0;
      req_chan.field_width = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random_formats(110);
      test_signed_padding(110);
      test_back_to_back(90);

      if (mismatches == 0 && expected_text.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule

### sim.f
rtl/pif_pkg.sv
rtl/pif_req_if.sv
rtl/pif_rsp_if.sv
rtl/printf_integer_formatter.sv
bench/tb.sv
